// ===== design/tlblru_pkg.sv =====
// Shared constants and types for the fully associative LRU TLB.
// Used by the controller, the datapath and the top level; depends on nothing.
package tlblru_pkg;

   localparam int ENTRIES    = 64;
   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 8;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int AGE_BITS   = IDX_BITS;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   typedef logic [ENTRIES-1:0]    entry_vec_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [AGE_BITS-1:0]   age_type;
   typedef logic [PAGE_BITS-1:0]  page_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic update;
   } ctrl_cmd_type;

endpackage

// ===== design/tlb_lru_lookup_fill_core.sv =====
// Top level of the 64-entry fully associative TLB with true LRU replacement.
// Instantiates tlblru_ctrl and tlblru_datapath; depends on tlblru_pkg.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_cmd, req_page, req_frame
//   rsp_      out        rsp_valid/rsp_stall  rsp_hit, rsp_frame_out, rsp_slot,
//                                             rsp_evicted, rsp_evicted_page
//
// Each request runs a parallel page match over all entries, then
// the rank and entry update that also loads the response register.
// A new request is accepted during the update cycle while responses are taken,
// so its match overlaps the presentation of the previous response.
// Reset is synchronous and clears the valid bits, ranks and fill count at once.
// A stalled response holds the update; a request may still be accepted and matched.
module tlb_lru_lookup_fill_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [tlblru_pkg::PAGE_BITS-1:0]  req_page,
   input  logic [tlblru_pkg::FRAME_BITS-1:0] req_frame,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [tlblru_pkg::FRAME_BITS-1:0] rsp_frame_out,
   output logic [tlblru_pkg::IDX_BITS-1:0]   rsp_slot,
   output logic                              rsp_evicted,
   output logic [tlblru_pkg::PAGE_BITS-1:0]  rsp_evicted_page
);

   tlblru_pkg::ctrl_cmd_type cmd;

   tlblru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tlblru_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_cmd          (req_cmd),
      .req_page         (req_page),
      .req_frame        (req_frame),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_slot         (rsp_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page)
   );

endmodule

// ===== design/tlblru_ctrl.sv =====
// Sequencer for the TLB: accepts a request, runs the match and update steps
// and owns the response valid flag. Depends on tlblru_pkg.
module tlblru_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlblru_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       take_req;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_UPDATE) && out_free));
   assign take_req  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = take_req;
      cmd.match   = 1'b0;
      cmd.update  = 1'b0;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.update = 1'b1;
               state_in   = take_req ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A match step is always followed by its update step.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MATCH |=> state_ff == ST_UPDATE)
      else $error("match step not followed by update");

   // An update always presents a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not produce a response");

   // An update waits while the previous response is still held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && !out_free |=> (state_ff == ST_UPDATE) && !$past(cmd.update))
      else $error("update overran a held response");

endmodule

// ===== design/tlblru_datapath.sv =====
// Entry storage, parallel page match, LRU rank update and response registers
// of the TLB. Driven by commands from tlblru_ctrl; depends on tlblru_pkg.
module tlblru_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tlblru_pkg::ctrl_cmd_type      cmd,
   input  logic                          req_cmd,
   input  logic [tlblru_pkg::PAGE_BITS-1:0]  req_page,
   input  logic [tlblru_pkg::FRAME_BITS-1:0] req_frame,
   output logic                          rsp_hit,
   output logic [tlblru_pkg::FRAME_BITS-1:0] rsp_frame_out,
   output logic [tlblru_pkg::IDX_BITS-1:0]   rsp_slot,
   output logic                          rsp_evicted,
   output logic [tlblru_pkg::PAGE_BITS-1:0]  rsp_evicted_page
);

   tlblru_pkg::entry_vec_type valid_ff;
   tlblru_pkg::page_type      page_ff [tlblru_pkg::ENTRIES];
   tlblru_pkg::frame_type     frame_ff [tlblru_pkg::ENTRIES];
   tlblru_pkg::age_type       age_ff [tlblru_pkg::ENTRIES];
   tlblru_pkg::count_type     used_count_ff;

   logic                      req_cmd_ff;
   tlblru_pkg::page_type      req_page_ff;
   tlblru_pkg::frame_type     req_frame_ff;

   tlblru_pkg::entry_vec_type tgt_ff;
   tlblru_pkg::entry_vec_type tgt_in;
   logic                      hit_ff;
   logic                      full_ff;

   logic                      rsp_hit_ff;
   tlblru_pkg::frame_type     rsp_frame_ff;
   tlblru_pkg::idx_type       rsp_slot_ff;
   logic                      rsp_evicted_ff;
   tlblru_pkg::page_type      rsp_evicted_page_ff;

   tlblru_pkg::entry_vec_type match_vec;
   tlblru_pkg::entry_vec_type free_vec;
   tlblru_pkg::entry_vec_type free_low;
   tlblru_pkg::entry_vec_type vic_vec;
   tlblru_pkg::entry_vec_type vic_low;
   logic                      full;

   tlblru_pkg::idx_type       idx;
   tlblru_pkg::age_type       old_age;
   tlblru_pkg::page_type      old_page;
   tlblru_pkg::frame_type     old_frame;
   tlblru_pkg::age_type       top_age;
   logic                      do_write;
   logic                      do_touch;
   logic                      do_add;
   logic                      evict;

   // Match step: compare every entry and pick the entry that the update will use.
   always_comb begin
      for (int i = 0; i < tlblru_pkg::ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (page_ff[i] == req_page_ff);
         vic_vec[i]   = valid_ff[i] && (age_ff[i] == '0);
      end
      free_vec = ~valid_ff;
      free_low = free_vec & (~free_vec + tlblru_pkg::entry_vec_type'(1));
      vic_low  = vic_vec & (~vic_vec + tlblru_pkg::entry_vec_type'(1));
      if (vic_low == '0) begin
         vic_low = tlblru_pkg::entry_vec_type'(1);
      end
      full = (used_count_ff == tlblru_pkg::COUNT_BITS'(tlblru_pkg::ENTRIES));
      if (match_vec != '0) begin
         tgt_in = match_vec;
      end else if (full) begin
         tgt_in = vic_low;
      end else begin
         tgt_in = free_low;
      end
   end

   // Update step: decode the chosen entry and read its old contents.
   always_comb begin
      idx       = '0;
      old_age   = '0;
      old_page  = '0;
      old_frame = '0;
      for (int i = 0; i < tlblru_pkg::ENTRIES; i++) begin
         if (tgt_ff[i]) begin
            idx       = idx | tlblru_pkg::IDX_BITS'(i);
            old_age   = old_age | age_ff[i];
            old_page  = old_page | page_ff[i];
            old_frame = old_frame | frame_ff[i];
         end
      end
      do_write = hit_ff || (req_cmd_ff == tlblru_pkg::CMD_FILL);
      evict    = !hit_ff && (req_cmd_ff == tlblru_pkg::CMD_FILL) && full_ff;
      do_add   = !hit_ff && (req_cmd_ff == tlblru_pkg::CMD_FILL) && !full_ff;
      do_touch = hit_ff || evict;
      if (do_add) begin
         top_age = tlblru_pkg::AGE_BITS'(used_count_ff);
      end else begin
         top_age = tlblru_pkg::AGE_BITS'(used_count_ff - tlblru_pkg::count_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= req_cmd;
         req_page_ff  <= req_page;
         req_frame_ff <= req_frame;
      end
      if (cmd.match) begin
         tgt_ff  <= tgt_in;
         hit_ff  <= (match_vec != '0);
         full_ff <= full;
      end
      if (cmd.update) begin
         rsp_hit_ff          <= hit_ff;
         rsp_frame_ff        <= hit_ff ? old_frame : '0;
         rsp_slot_ff         <= do_write ? idx : '0;
         rsp_evicted_ff      <= evict;
         rsp_evicted_page_ff <= evict ? old_page : '0;
      end
      for (int i = 0; i < tlblru_pkg::ENTRIES; i++) begin
         if (cmd.update && (req_cmd_ff == tlblru_pkg::CMD_FILL) && tgt_ff[i]) begin
            page_ff[i]  <= req_page_ff;
            frame_ff[i] <= req_frame_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         used_count_ff <= '0;
         for (int i = 0; i < tlblru_pkg::ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd.update && do_write) begin
         if (do_add) begin
            used_count_ff <= used_count_ff + tlblru_pkg::count_type'(1);
         end
         for (int i = 0; i < tlblru_pkg::ENTRIES; i++) begin
            if (tgt_ff[i]) begin
               valid_ff[i] <= 1'b1;
               age_ff[i]   <= top_age;
            end else if (do_touch && valid_ff[i] && (age_ff[i] > old_age)) begin
               age_ff[i] <= age_ff[i] - tlblru_pkg::age_type'(1);
            end
         end
      end
   end

   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_out    = rsp_frame_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

   // A fill never creates a second copy of a page.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page present in more than one entry");

   // Every write goes to exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      cmd.update && do_write |-> $onehot(tgt_ff))
      else $error("write target is not a single entry");

   // The fill count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= tlblru_pkg::COUNT_BITS'(tlblru_pkg::ENTRIES))
      else $error("fill count beyond table size");

endmodule
